[sv/cfa_pkg.sv]
// Shared types, constants and codes of the contiguous frame allocator.
package cfa_pkg;

  localparam int MAX_FRAMES_DEF = 1024;
  localparam int WORD_W = 16;
  localparam int WORD_LW = 4;
  localparam int CNT_W = 17;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  localparam logic REG_TOTAL_FRAMES = 1'b0;
  localparam logic REG_FIRST_FREE = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_SW_RD,
    S_SW_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        cmd;
    logic [10:0] npages;
    logic [9:0]  frame;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] start_frame;
    logic       from_bump;
  } rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0] run_start;
    logic             hit;
    logic [CNT_W-1:0] hit_start;
  } link_t;

endpackage

[sv/cfa_ram.sv]
// Generic simple dual-port RAM with registered read.
module cfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/cfa_cell.sv]
// One frame slot of the scan row: tracks the open run and flags the first fit.
module cfa_cell (
  input  logic                    free_bit,
  input  logic [cfa_pkg::CNT_W-1:0] idx,
  input  logic [cfa_pkg::CNT_W-1:0] n,
  input  logic [cfa_pkg::CNT_W-1:0] tcap,
  input  cfa_pkg::link_t          link_i,
  output cfa_pkg::link_t          link_o
);

  logic usable;
  logic fits;

  assign usable = free_bit && (idx <= tcap);
  assign fits = usable && !link_i.hit && (idx >= link_i.run_start + n);

  always_comb begin
    link_o = link_i;
    if (!usable) begin
      link_o.run_start = idx;
    end
    if (fits) begin
      link_o.hit = 1'b1;
      link_o.hit_start = idx - n;
    end
  end

endmodule

[sv/cfa_row.sv]
// Row of scan cells covering one bitmap word.
module cfa_row (
  input  logic [cfa_pkg::WORD_W-1:0] bits,
  input  logic [cfa_pkg::CNT_W-1:0]  base,
  input  logic [cfa_pkg::CNT_W-1:0]  n,
  input  logic [cfa_pkg::CNT_W-1:0]  tcap,
  input  cfa_pkg::link_t             link_i,
  output cfa_pkg::link_t             link_o
);

  cfa_pkg::link_t chain [cfa_pkg::WORD_W+1];

  assign chain[0] = link_i;

  for (genvar k = 0; k < cfa_pkg::WORD_W; k++) begin : g_cell
    cfa_cell u_cell (
      .free_bit (bits[k]),
      .idx      (base + cfa_pkg::CNT_W'(k + 1)),
      .n        (n),
      .tcap     (tcap),
      .link_i   (chain[k]),
      .link_o   (chain[k+1])
    );
  end

  assign link_o = chain[cfa_pkg::WORD_W];

endmodule

[sv/contiguous_frame_allocator_unit.sv]
// Top level of the contiguous frame allocator: control, bitmap and size tables.
// After reset the block clears its size table and its bitmap, one entry a cycle,
// taking no request meanwhile. An allocate scans the free bitmap one
// 16-frame word per cycle through a row of cells, then does a read-modify-write
// of the bitmap on each word touched; a bump allocation ends at the scan. A free
// looks up the size, then does a read-modify-write on each word set free. The
// done state then hands the result to the output register; the bitmap memory
// port is the bound on all of these.
module contiguous_frame_allocator_unit #(
  parameter int MAX_FRAMES = cfa_pkg::MAX_FRAMES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  cfa_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cfa_pkg::rsp_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [10:0]   cfg_data
);

  localparam int CW = cfa_pkg::CNT_W;
  localparam int W = cfa_pkg::WORD_W;
  localparam int LW = cfa_pkg::WORD_LW;
  localparam int RAW = MAX_FRAMES > 1 ? $clog2(MAX_FRAMES) : 1;
  localparam int NW = (MAX_FRAMES + W - 1) / W;
  localparam int WAW = NW > 1 ? $clog2(NW) : 1;

  cfa_pkg::state_t state, state_next;
  cfa_pkg::req_t   req, req_next;
  cfa_pkg::rsp_t   res, res_next;

  logic [10:0]   total_frames;
  logic [10:0]   bump_next, bump_next_next;
  logic [CW-1:0] n, n_next;
  logic [CW-1:0] run_start, run_start_next;
  logic [CW-1:0] rd_ptr, rd_ptr_next;
  logic          pv, pv_next;
  logic [CW-1:0] pw, pw_next;
  logic [CW-1:0] sw_ptr, sw_ptr_next;
  logic [CW-1:0] sw_last, sw_last_next;
  logic [CW-1:0] lo, lo_next;
  logic [CW-1:0] hi, hi_next;
  logic          setop, setop_next;
  logic [RAW-1:0] clr_ptr;

  logic [CW-1:0] tcap, nwords, req_n, req_f, len, fend, bump_w;
  logic          in_acc, cfg_acc, out_load;
  logic          bump_ok, clr_last;

  logic          bm_we;
  logic [WAW-1:0] bm_waddr, bm_raddr;
  logic [W-1:0]  bm_wdata, bm_rdata, sw_mask;
  logic          rl_we;
  logic [RAW-1:0] rl_waddr, rl_raddr;
  logic [10:0]   rl_wdata, rl_rdata;

  cfa_pkg::link_t link_in, link_out;

  assign tcap = (CW'(total_frames) > CW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(total_frames);
  assign nwords = (tcap + CW'(W - 1)) >> LW;
  assign req_n = CW'(in_data.npages);
  assign req_f = CW'(in_data.frame);
  assign len = CW'(rl_rdata);
  assign fend = (CW'(req.frame) + len > tcap) ? tcap : CW'(req.frame) + len;
  assign bump_w = CW'(bump_next);
  assign bump_ok = (bump_w <= tcap) && (n <= tcap - bump_w);
  assign clr_last = (clr_ptr == RAW'(MAX_FRAMES - 1));

  assign in_stall = (state != cfa_pkg::S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_acc = cfg_valid && cfg_ready;
  assign out_load = (state == cfa_pkg::S_DONE) && !(out_valid && out_stall);

  assign link_in.run_start = run_start;
  assign link_in.hit = 1'b0;
  assign link_in.hit_start = '0;

  cfa_row u_row (
    .bits   (bm_rdata),
    .base   (pw << LW),
    .n      (n),
    .tcap   (tcap),
    .link_i (link_in),
    .link_o (link_out)
  );

  always_comb begin
    for (int k = 0; k < W; k++) begin
      sw_mask[k] = ((sw_ptr << LW) + CW'(k) >= lo) && ((sw_ptr << LW) + CW'(k) < hi);
    end
  end

  cfa_ram #(.WIDTH(W), .DEPTH(NW)) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  cfa_ram #(.WIDTH(11), .DEPTH(MAX_FRAMES)) u_run_length (
    .clk   (clk),
    .we    (rl_we),
    .waddr (rl_waddr),
    .wdata (rl_wdata),
    .raddr (rl_raddr),
    .rdata (rl_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      cfa_pkg::S_CLEAR: begin
        if (clr_last) begin
          state_next = cfa_pkg::S_IDLE;
        end
      end
      cfa_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_data.cmd == cfa_pkg::CMD_ALLOC) begin
            state_next = (req_n == '0 || req_n > tcap) ? cfa_pkg::S_DONE : cfa_pkg::S_SCAN;
          end else begin
            state_next = (req_f >= tcap) ? cfa_pkg::S_DONE : cfa_pkg::S_FREE_RD;
          end
        end
      end
      cfa_pkg::S_SCAN: begin
        if (pv && link_out.hit) begin
          state_next = cfa_pkg::S_SW_RD;
        end else if (pv && pw == nwords - CW'(1)) begin
          state_next = cfa_pkg::S_DONE;
        end
      end
      cfa_pkg::S_FREE_RD: begin
        state_next = (len == '0) ? cfa_pkg::S_DONE : cfa_pkg::S_SW_RD;
      end
      cfa_pkg::S_SW_RD: begin
        state_next = cfa_pkg::S_SW_WR;
      end
      cfa_pkg::S_SW_WR: begin
        state_next = (sw_ptr == sw_last) ? cfa_pkg::S_DONE : cfa_pkg::S_SW_RD;
      end
      cfa_pkg::S_DONE: begin
        if (out_load) begin
          state_next = cfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = cfa_pkg::S_CLEAR;
      end
    endcase
  end

  always_comb begin
    req_next = req;
    res_next = res;
    n_next = n;
    run_start_next = run_start;
    rd_ptr_next = rd_ptr;
    pv_next = 1'b0;
    pw_next = pw;
    sw_ptr_next = sw_ptr;
    sw_last_next = sw_last;
    lo_next = lo;
    hi_next = hi;
    setop_next = setop;
    bump_next_next = bump_next;
    bm_we = 1'b0;
    bm_waddr = sw_ptr[WAW-1:0];
    bm_wdata = setop ? (bm_rdata | sw_mask) : (bm_rdata & ~sw_mask);
    bm_raddr = sw_ptr[WAW-1:0];
    rl_we = 1'b0;
    rl_waddr = clr_ptr;
    rl_wdata = '0;
    rl_raddr = req_f[RAW-1:0];
    unique case (state)
      cfa_pkg::S_CLEAR: begin
        rl_we = 1'b1;
        bm_we = CW'(clr_ptr) < CW'(NW);
        bm_waddr = clr_ptr[WAW-1:0];
        bm_wdata = '0;
      end
      cfa_pkg::S_IDLE: begin
        if (in_acc) begin
          req_next = in_data;
          n_next = req_n;
          run_start_next = '0;
          rd_ptr_next = '0;
          res_next.status = cfa_pkg::ST_BAD;
          res_next.start_frame = '0;
          res_next.from_bump = 1'b0;
        end
      end
      cfa_pkg::S_SCAN: begin
        bm_raddr = rd_ptr[WAW-1:0];
        if (rd_ptr < nwords) begin
          pv_next = 1'b1;
          pw_next = rd_ptr;
          rd_ptr_next = rd_ptr + CW'(1);
        end
        if (pv) begin
          run_start_next = link_out.run_start;
          if (link_out.hit) begin
            lo_next = link_out.hit_start;
            hi_next = link_out.hit_start + n;
            sw_ptr_next = link_out.hit_start >> LW;
            sw_last_next = (link_out.hit_start + n - CW'(1)) >> LW;
            setop_next = 1'b0;
            rl_we = 1'b1;
            rl_waddr = link_out.hit_start[RAW-1:0];
            rl_wdata = n[10:0];
            res_next.status = cfa_pkg::ST_OK;
            res_next.start_frame = link_out.hit_start[9:0];
            res_next.from_bump = 1'b0;
          end else if (pw == nwords - CW'(1)) begin
            if (bump_ok) begin
              rl_we = 1'b1;
              rl_waddr = bump_w[RAW-1:0];
              rl_wdata = n[10:0];
              bump_next_next = 11'(bump_w + n);
              res_next.status = cfa_pkg::ST_OK;
              res_next.start_frame = bump_next[9:0];
              res_next.from_bump = 1'b1;
            end else begin
              res_next.status = cfa_pkg::ST_NOSPACE;
            end
          end
        end
      end
      cfa_pkg::S_FREE_RD: begin
        if (len != '0) begin
          lo_next = CW'(req.frame);
          hi_next = fend;
          sw_ptr_next = CW'(req.frame) >> LW;
          sw_last_next = (fend - CW'(1)) >> LW;
          setop_next = 1'b1;
          rl_we = 1'b1;
          rl_waddr = lo_next[RAW-1:0];
          rl_wdata = '0;
          res_next.status = cfa_pkg::ST_OK;
          res_next.start_frame = req.frame;
          res_next.from_bump = 1'b0;
        end
      end
      cfa_pkg::S_SW_RD: begin
      end
      cfa_pkg::S_SW_WR: begin
        bm_we = 1'b1;
        if (sw_ptr != sw_last) begin
          sw_ptr_next = sw_ptr + CW'(1);
        end
        bm_raddr = sw_ptr_next[WAW-1:0];
      end
      cfa_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
    if (cfg_acc && cfg_index == cfa_pkg::REG_FIRST_FREE) begin
      bump_next_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfa_pkg::S_CLEAR;
      clr_ptr <= '0;
      pv <= 1'b0;
      out_valid <= 1'b0;
      total_frames <= 11'd1024;
      bump_next <= '0;
    end else begin
      state <= state_next;
      pv <= pv_next;
      bump_next <= bump_next_next;
      if (state == cfa_pkg::S_CLEAR) begin
        clr_ptr <= clr_ptr + RAW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_acc) begin
        unique case (cfg_index)
          cfa_pkg::REG_TOTAL_FRAMES: total_frames <= cfg_data;
          cfa_pkg::REG_FIRST_FREE: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    req <= req_next;
    res <= res_next;
    n <= n_next;
    run_start <= run_start_next;
    rd_ptr <= rd_ptr_next;
    pw <= pw_next;
    sw_ptr <= sw_ptr_next;
    sw_last <= sw_last_next;
    lo <= lo_next;
    hi <= hi_next;
    setop <= setop_next;
    if (out_load) begin
      out_data <= res;
    end
  end

  a_scan_word_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == cfa_pkg::S_SCAN && pv) |-> (pw < nwords))
    else $error("scan word beyond managed frames");

  a_sweep_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == cfa_pkg::S_SW_WR) |-> (sw_ptr <= sw_last))
    else $error("bitmap sweep past its last word");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && state == cfa_pkg::S_IDLE))
    else $error("result not presented after completion");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (state == cfa_pkg::S_CLEAR && !out_valid))
    else $error("reset did not start the clearing pass");

endmodule

[tb/tb_contiguous_frame_allocator_unit.sv]
// Testbench of the contiguous frame allocator: directed and random requests checked by a scoreboard.
`timescale 1ns / 100ps

class frame_alloc_scoreboard;
  bit [10:0] total_frames;
  bit [10:0] bump_next;
  bit        free_map [1024];
  bit [10:0] run_length [1024];
  cfa_pkg::rsp_t pending [$];
  int errors;

  function new();
    total_frames = 11'd1024;
    bump_next = 11'd0;
    errors = 0;
    foreach (free_map[i]) begin
      free_map[i] = 1'b0;
      run_length[i] = 11'd0;
    end
  endfunction

  function void write_reg(logic idx, bit [10:0] val);
    if (idx == cfa_pkg::REG_TOTAL_FRAMES) begin
      total_frames = val;
    end else begin
      bump_next = val;
    end
  endfunction

  function void note_request(cfa_pkg::req_t req);
    cfa_pkg::rsp_t r;
    int t, cnt, start, n, f, stop;
    bit found;
    t = (total_frames > 1024) ? 1024 : total_frames;
    r = '0;
    r.status = cfa_pkg::ST_BAD;
    found = 1'b0;
    cnt = 0;
    start = 0;
    if (req.cmd == cfa_pkg::CMD_ALLOC) begin
      n = req.npages;
      if (n != 0 && n <= t) begin
        for (int i = 0; i < t && !found; i++) begin
          if (free_map[i]) begin
            cnt++;
            if (cnt >= n) begin
              start = i + 1 - n;
              found = 1'b1;
            end
          end else begin
            cnt = 0;
          end
        end
        if (found) begin
          for (int i = start; i < start + n; i++) free_map[i] = 1'b0;
          run_length[start] = 11'(n);
          r.status = cfa_pkg::ST_OK;
          r.start_frame = 10'(start);
        end else if (bump_next <= t && n <= t - bump_next) begin
          start = bump_next;
          bump_next = 11'(start + n);
          run_length[start] = 11'(n);
          r.status = cfa_pkg::ST_OK;
          r.start_frame = 10'(start);
          r.from_bump = 1'b1;
        end else begin
          r.status = cfa_pkg::ST_NOSPACE;
        end
      end
    end else begin
      f = req.frame;
      if (f < t && run_length[f] != 0) begin
        stop = f + run_length[f];
        if (stop > t) stop = t;
        for (int i = f; i < stop; i++) free_map[i] = 1'b1;
        run_length[f] = 11'd0;
        r.status = cfa_pkg::ST_OK;
        r.start_frame = 10'(f);
      end
    end
    pending.push_back(r);
  endfunction

  function void check_result(cfa_pkg::rsp_t got);
    cfa_pkg::rsp_t exp;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
    end else begin
      exp = pending.pop_front();
      if (got.status !== exp.status || got.start_frame !== exp.start_frame ||
          got.from_bump !== exp.from_bump) begin
        $display("%0t: mismatch expected %h actual %h", $time, exp, got);
        errors++;
      end
    end
  endfunction
endclass

module tb_contiguous_frame_allocator_unit;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  cfa_pkg::req_t in_data;
  cfa_pkg::rsp_t out_data;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [10:0] cfg_data;

  frame_alloc_scoreboard sb;
  int send_idle, recv_stall;
  bit hold_off;
  int cycles;
  int live [$];

  contiguous_frame_allocator_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("tb_contiguous_frame_allocator_unit failed");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= hold_off || ($urandom_range(99) < recv_stall);
  end

  task automatic send_req(logic cmd, logic [10:0] n, logic [9:0] f);
    cfa_pkg::req_t r;
    while ($urandom_range(99) < send_idle) begin
      @(posedge clk);
      in_valid <= 1'b0;
      in_data <= cfa_pkg::req_t'($urandom);
    end
    r.cmd = cmd;
    r.npages = n;
    r.frame = f;
    @(posedge clk);
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    in_valid <= 1'b0;
  endtask

  task automatic write_cfg(logic idx, logic [10:0] val);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_req(int tmax);
    int k;
    logic [10:0] n;
    if (live.size() != 0 && $urandom_range(99) < 45) begin
      k = $urandom_range(live.size() - 1);
      send_req(cfa_pkg::CMD_FREE, 11'($urandom), 10'(live[k]));
      live.delete(k);
    end else if ($urandom_range(99) < 8) begin
      send_req(1'($urandom), 11'($urandom), 10'($urandom));
    end else begin
      n = ($urandom_range(9) == 0) ? 11'($urandom_range(tmax)) : 11'($urandom_range(1, 12));
      send_req(cfa_pkg::CMD_ALLOC, n, 10'($urandom));
      while (sb.pending.size() != 0) @(posedge clk);
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    send_idle = 0;
    recv_stall = 0;
    hold_off = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (in_stall) @(posedge clk);

    send_req(cfa_pkg::CMD_ALLOC, 11'd0, 10'd0);
    send_req(cfa_pkg::CMD_ALLOC, 11'd1025, 10'd0);
    send_req(cfa_pkg::CMD_ALLOC, 11'd2047, 10'd0);
    send_req(cfa_pkg::CMD_FREE, 11'd0, 10'd0);
    send_req(cfa_pkg::CMD_ALLOC, 11'd1, 10'd0);
    send_req(cfa_pkg::CMD_ALLOC, 11'd4, 10'd1023);
    send_req(cfa_pkg::CMD_FREE, 11'd0, 10'd0);
    send_req(cfa_pkg::CMD_FREE, 11'd0, 10'd0);
    send_req(cfa_pkg::CMD_FREE, 11'd0, 10'd3);
    send_req(cfa_pkg::CMD_ALLOC, 11'd1, 10'd0);
    send_req(cfa_pkg::CMD_ALLOC, 11'd1019, 10'd0);
    send_req(cfa_pkg::CMD_ALLOC, 11'd1, 10'd0);
    send_req(cfa_pkg::CMD_FREE, 11'd0, 10'd1);
    send_req(cfa_pkg::CMD_ALLOC, 11'd1024, 10'd0);
    send_req(cfa_pkg::CMD_ALLOC, 11'd2, 10'd0);
    send_req(cfa_pkg::CMD_FREE, 11'd0, 10'd1023);
    write_cfg(cfa_pkg::REG_TOTAL_FRAMES, 11'd500);
    send_req(cfa_pkg::CMD_FREE, 11'd0, 10'd600);
    send_req(cfa_pkg::CMD_FREE, 11'd0, 10'd5);
    write_cfg(cfa_pkg::REG_TOTAL_FRAMES, 11'd2047);
    write_cfg(cfa_pkg::REG_FIRST_FREE, 11'd2047);
    send_req(cfa_pkg::CMD_ALLOC, 11'd952, 10'd0);
    send_req(cfa_pkg::CMD_ALLOC, 11'd1, 10'd0);

    for (int ph = 0; ph < 12; ph++) begin
      int tf, ff;
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 77; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 77; end
        default: begin send_idle = 13; recv_stall = 13; end
      endcase
      tf = (ph == 0) ? 1 : (ph == 1) ? 1024 : (ph == 2) ? 2047 : $urandom_range(16, 1024);
      ff = (ph == 3) ? 1024 : (ph == 4) ? 0 : $urandom_range(tf > 1024 ? 1024 : tf);
      write_cfg(cfa_pkg::REG_TOTAL_FRAMES, 11'(tf));
      write_cfg(cfa_pkg::REG_FIRST_FREE, 11'(ff));
      live.delete();
      for (int i = 0; i < 160; i++) begin
        random_req(tf > 1024 ? 1024 : tf);
        live.delete();
        for (int q = 0; q < 1024; q++) if (sb.run_length[q] != 0) live.push_back(q);
      end
      if (ph == 5) begin
        hold_off = 1'b1;
        fork
          begin repeat (600) @(posedge clk); hold_off = 1'b0; end
          for (int i = 0; i < 8; i++) send_req(cfa_pkg::CMD_ALLOC, 11'd1, 10'd0);
        join
      end
    end

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_contiguous_frame_allocator_unit passed");
    end else begin
      $display("tb_contiguous_frame_allocator_unit failed");
    end
    $finish;
  end
endmodule
